// File: rtl/dts_pkg.sv
// Shared types, codes and constant tables for the decaying tone synth.
// Used by dts_ctrl, dts_dp and decaying_tone_synth; depends on nothing.
`default_nettype none

package dts_pkg;

  localparam int VOL_W    = 28;
  localparam int DECAY_W  = 16;
  localparam int KEY_W    = 8;
  localparam int SAMPLE_W = 32;
  localparam int VIDX_W   = 5;   // voice number as carried on the command bus
  localparam int FREQ_W   = 26;  // unsigned Q10.16 frequency
  localparam int MAG_W    = 15;  // sine magnitude
  localparam int ACC_W    = 35;  // up to 32 terms of 29 bits signed
  localparam int CFG_IDX_W = 2;
  localparam int MAX_VOICES = 32;

  // operation codes
  localparam logic OP_PRESS = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd2;

  localparam logic [VOL_W-1:0]   PEAK_RESET  = 28'h9D89D89;
  localparam logic [VOL_W-1:0]   FLOOR_RESET = 28'h09D89D8;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd65503;

  // voice frequencies, round(Hz * 65536)
  localparam logic [FREQ_W-1:0] VOICE_FREQ [MAX_VOICES] = '{
    26'd18165465, 26'd20390019, 26'd0,        26'd24247927, 26'd27217428,
    26'd30550524, 26'd17145922, 26'd19245629, 26'd21602501, 26'd22887006,
    26'd25689784, 26'd28835840, 26'd32367116, 26'd34291778,
    26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0,
    26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              press;       // load peak into the pressed voice
    logic              tick_start;  // clear the accumulator
    logic              read;        // fetch volume and sine, advance phase
    logic              mult;        // form term and decay products
    logic              acc;         // add term, write back decayed volume
    logic              finish;      // load output, advance sample count
    logic [VIDX_W-1:0] voice;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic [VIDX_W-1:0] voice;
  } key_map_t;

  function automatic key_map_t map_key(input logic [KEY_W-1:0] key);
    key_map_t m;
    m.hit   = 1'b0;
    m.voice = '0;
    case (key) inside
      8'd3, 8'd4, [8'd6:8'd8]: begin
        m.hit   = 1'b1;
        m.voice = VIDX_W'(key - 8'd3);
      end
      [8'd16:8'd23]: begin
        m.hit   = 1'b1;
        m.voice = VIDX_W'(key - 8'd10);
      end
      default: begin
        m.hit = 1'b0;
      end
    endcase
    return m;
  endfunction

  // Sine table entry as sign (bit 15) and magnitude, elaboration only.
  // Quarter-wave fold, odd degree-9 polynomial in Q30, rounded to 32767*sin.
  function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned bits);
    logic [63:0] quarter;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] mag;
    quarter = 64'd1 << (bits - 2);
    quad    = (64'(idx) >> (bits - 2)) & 64'd3;
    r       = 64'(idx) & (quarter - 64'd1);
    if (quad[0]) r = quarter - r;
    u  = r << (30 - (bits - 2));
    u2 = (u * u) >> 30;
    s  = 64'd172272;
    s  = 64'd5026996 - ((u2 * s) >> 30);
    s  = 64'd85569307 - ((u2 * s) >> 30);
    s  = 64'd693598668 - ((u2 * s) >> 30);
    s  = 64'd1686629713 - ((u2 * s) >> 30);
    v  = (u * s) >> 30;
    mag = (v * 64'd32767 + 64'd536870912) >> 30;
    if (mag > 64'd32767) mag = 64'd32767;
    return {quad[1], mag[MAG_W-1:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/dts_ctrl.sv
// Sequencer for the tone synth: handshakes and the per-voice pass of a tick.
// Uses dts_pkg; drives the dts_dp command bus.
`default_nettype none

module dts_ctrl
  import dts_pkg::*;
#(
  parameter int VOICES = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_operation,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [VIDX_W-1:0] voice_r, voice_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_take;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      voice_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      voice_r     <= voice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    voice_nxt     = voice_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.voice     = voice_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_operation == OP_TICK) begin
            cmd.tick_start = 1'b1;
            voice_nxt      = '0;
            state_nxt      = ST_READ;
          end else begin
            cmd.press = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (voice_r == LAST_VOICE) begin
          state_nxt = ST_DONE;
        end else begin
          voice_nxt = voice_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        // hold the sum until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/dts_dp.sv
// Datapath for the tone synth: config registers, voice volumes, phase trackers,
// sine ROM, the two multipliers, accumulator and output register. Uses dts_pkg.
`default_nettype none

module dts_dp
  import dts_pkg::*;
#(
  parameter int VOICES           = 14,
  parameter int SAMPLES_PER_WRAP = 8000,
  parameter int SINE_TABLE_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [KEY_W-1:0]     key_code,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VOL_W-1:0]     cfg_wdata,
  output logic [SAMPLE_W-1:0]  sample_out
);

  localparam int VW         = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W      = (SAMPLES_PER_WRAP > 1) ? $clog2(SAMPLES_PER_WRAP) : 1;
  localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
  localparam logic [47:0] DIV = 48'(SAMPLES_PER_WRAP) << 16;
  localparam int R_W        = $clog2(DIV);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_WRAP - 1);
  localparam logic [R_W:0]     DIV_EXT  = (R_W + 1)'(DIV);

  // configuration
  logic [VOL_W-1:0]   peak_r, floor_r;
  logic [DECAY_W-1:0] decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= PEAK_RESET;
      floor_r <= FLOOR_RESET;
      decay_r <= DECAY_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PEAK:  peak_r  <= cfg_wdata;
        CFG_FLOOR: floor_r <= cfg_wdata;
        CFG_DECAY: decay_r <= cfg_wdata[DECAY_W-1:0];
        default:   ;
      endcase
    end
  end

  // per-voice phase step: quotient and remainder of freq*2^B by the wrap length
  logic [SINE_TABLE_BITS-1:0] qs_w [VOICES];
  logic [R_W-1:0]             rs_w [VOICES];
  logic [15:0]                sine_rom [SINE_DEPTH];

  for (genvar g = 0; g < VOICES; g++) begin : g_step
    localparam logic [63:0] STEP = 64'(VOICE_FREQ[g]) << SINE_TABLE_BITS;
    localparam logic [63:0] QS   = STEP / 64'(DIV);
    localparam logic [63:0] RS   = STEP % 64'(DIV);
    assign qs_w[g] = QS[SINE_TABLE_BITS-1:0];
    assign rs_w[g] = RS[R_W-1:0];
  end

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(g, SINE_TABLE_BITS);
    assign sine_rom[g] = ENTRY;
  end

  logic [VW-1:0]              v;
  key_map_t                   km;
  logic                       press_hit;
  logic [CNT_W-1:0]           count_r;
  logic                       wrap;
  logic [SINE_TABLE_BITS-1:0] q_r [VOICES];
  logic [R_W-1:0]             r_r [VOICES];
  logic [R_W:0]               r_sum;
  logic                       carry;
  logic [R_W-1:0]             r_nxt;
  logic [SINE_TABLE_BITS-1:0] q_nxt;

  assign v         = cmd.voice[VW-1:0];
  assign km        = map_key(key_code);
  assign press_hit = km.hit && ({1'b0, km.voice} < 6'(VOICES));
  assign wrap      = (count_r == CNT_LAST);

  always_comb begin
    r_sum = {1'b0, r_r[v]} + {1'b0, rs_w[v]};
    carry = (r_sum >= DIV_EXT);
    if (carry) r_sum = r_sum - DIV_EXT;
    r_nxt = r_sum[R_W-1:0];
    q_nxt = q_r[v] + qs_w[v] + SINE_TABLE_BITS'(carry);
    if (wrap) begin
      r_nxt = '0;
      q_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        q_r[i] <= '0;
        r_r[i] <= '0;
      end
    end else if (cmd.read) begin
      q_r[v] <= q_nxt;
      r_r[v] <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= wrap ? '0 : count_r + 1'b1;
    end
  end

  // volume store, fetch, multiply, accumulate
  logic [VOL_W-1:0]         vol_r [VOICES];
  logic [VOL_W-1:0]         vol_q_r;
  logic [15:0]              sine_r;
  logic [VOL_W+MAG_W-1:0]   term_p_r;
  logic [VOL_W+DECAY_W-1:0] dec_p_r;
  logic                     neg_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  term_ext;
  logic [VOL_W-1:0]         dec_vol;
  logic [SAMPLE_W-1:0]      sample_r;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

  assign term_ext = ACC_W'(term_p_r[VOL_W+MAG_W-1:MAG_W]);
  assign dec_vol  = dec_p_r[VOL_W+DECAY_W-1:DECAY_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) vol_r[i] <= '0;
    end else if (cmd.press && press_hit) begin
      vol_r[km.voice[VW-1:0]] <= peak_r;
    end else if (cmd.acc) begin
      vol_r[v] <= (dec_vol < floor_r) ? '0 : dec_vol;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      vol_q_r <= vol_r[v];
      sine_r  <= sine_rom[q_r[v]];
    end
    if (cmd.mult) begin
      term_p_r <= vol_q_r * sine_r[MAG_W-1:0];
      dec_p_r  <= vol_q_r * decay_r;
      neg_r    <= sine_r[15];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      acc_r <= '0;
    end else if (cmd.acc) begin
      acc_r <= neg_r ? acc_r - term_ext : acc_r + term_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (acc_r > SAT_MAX) begin
        sample_r <= SAT_MAX[SAMPLE_W-1:0];
      end else if (acc_r < SAT_MIN) begin
        sample_r <= SAT_MIN[SAMPLE_W-1:0];
      end else begin
        sample_r <= acc_r[SAMPLE_W-1:0];
      end
    end
  end

  assign sample_out = sample_r;

endmodule

`default_nettype wire

// File: rtl/decaying_tone_synth.sv
// Top level of the decaying tone synth: ties the sequencer to the datapath.
// Uses dts_pkg, dts_ctrl and dts_dp.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   in      | in_valid/in_stall, operation, key   | request in
//   out     | out_valid/out_stall, sample_out     | request out
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata     | write only
//
// A key press does not leave the idle state, so the next request can be taken the cycle after.
// A tick runs one read-multiply-accumulate pass per voice (states READ, MULT, ACC),
// then waits in DONE; in_stall stays high from accept until the sequencer is idle again.
// Synchronous reset clears volumes, phases, sample count and config to defaults.
// A tick result waits in the output register; a press is still taken meanwhile,
// and a following tick holds its sum until out_stall lets the register go.
`default_nettype none

module decaying_tone_synth
  import dts_pkg::*;
#(
  parameter int VOICES           = 14,
  parameter int SAMPLES_PER_WRAP = 8000,
  parameter int SINE_TABLE_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [KEY_W-1:0]     in_key_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SAMPLE_W-1:0]  out_sample_out,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VOL_W-1:0]     cfg_wdata
);

  cmd_t cmd;

  dts_ctrl #(
    .VOICES(VOICES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  dts_dp #(
    .VOICES           (VOICES),
    .SAMPLES_PER_WRAP (SAMPLES_PER_WRAP),
    .SINE_TABLE_BITS  (SINE_TABLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .key_code   (in_key_code),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .sample_out (out_sample_out)
  );

`ifndef NO_ASSERTIONS
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_TICK) |=> in_stall)
    else $error("request taken while tick in progress");

  a_read_mult: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |=> (cmd.mult && $stable(cmd.voice)))
    else $error("voice pass out of order");
`endif

endmodule

`default_nettype wire
